@@ rtl/lot_pkg.sv @@
// shared types and codes for the layer order table
package lot_pkg;

    // fixed widths of the request and response fields
    localparam int ACTION_W = 3;
    localparam int WIN_ID_W = 16;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    typedef logic [ACTION_W-1:0] action_t;

    // request codes
    localparam action_t ACT_OPEN     = 3'd0;
    localparam action_t ACT_DESTROY  = 3'd1;
    localparam action_t ACT_RAISE    = 3'd2;
    localparam action_t ACT_ACTIVATE = 3'd3;
    localparam action_t ACT_QUERY    = 3'd4;

    // per-cycle operation broadcast to every cell
    typedef logic [2:0] cell_op_t;

    localparam cell_op_t CELL_HOLD   = 3'd0;
    localparam cell_op_t CELL_MATCH  = 3'd1;
    localparam cell_op_t CELL_PUSH   = 3'd2;
    localparam cell_op_t CELL_REMOVE = 3'd3;
    localparam cell_op_t CELL_LIFT   = 3'd4;

    // control from the sequencer to the cells
    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-1:0] qpos;
    } cell_ctl_t;

    // status from a cell back to the sequencer and its neighbors
    typedef struct packed {
        logic valid;
        logic hit;
        logic qsel;
    } cell_stat_t;

    // sequencer states
    typedef logic [2:0] seq_state_t;

    localparam seq_state_t S_IDLE  = 3'd0;
    localparam seq_state_t S_MATCH = 3'd1;
    localparam seq_state_t S_EXEC  = 3'd2;
    localparam seq_state_t S_TOP   = 3'd3;
    localparam seq_state_t S_OUT   = 3'd4;

endpackage

@@ rtl/lot_if.sv @@
// request and response channel interfaces of the layer order table
interface lot_req_if
    import lot_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [WIN_ID_W-1:0] window_id;
    logic [POS_W-1:0]    stack_position;

    modport source (output valid, action, window_id, stack_position, input ready);
    modport sink   (input valid, action, window_id, stack_position, output ready);
endinterface

interface lot_rsp_if
    import lot_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                ok;
    logic [WIN_ID_W-1:0] result_id;
    logic [COUNT_W-1:0]  entry_count;
    logic [WIN_ID_W-1:0] active_id;

    modport source (output valid, ok, result_id, entry_count, active_id, input ready);
    modport sink   (input valid, ok, result_id, entry_count, active_id, output ready);
endinterface

@@ rtl/lot_cell.sv @@
// one order position of the table: holds an id and trades it with its neighbors
module lot_cell
    import lot_pkg::*;
#(
    parameter int INDEX   = 0,
    parameter int ID_BITS = 16,
    parameter int KEY_W   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic [KEY_W-1:0]   key,
    input  logic               shift_en,
    input  logic               lower_valid,
    input  logic               upper_valid,
    input  logic [ID_BITS-1:0] upper_id,
    output cell_stat_t         stat,
    output logic [ID_BITS-1:0] id,
    output logic [ID_BITS-1:0] sel_term,
    output logic [ID_BITS-1:0] top_term
);

    logic               valid_reg, valid_next;
    logic               hit_reg, hit_next;
    logic               qsel_reg, qsel_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic               key_hit;
    logic               pos_hit;

    // compare against the broadcast key and query position
    assign key_hit = valid_reg && (KEY_W'(id_reg) == key) && (key != '0);
    assign pos_hit = valid_reg && (INDEX < (1 << POS_W)) && (ctl.qpos == POS_W'(INDEX));

    // next state of the cell
    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        qsel_next  = qsel_reg;
        id_next    = id_reg;
        case (ctl.op)
            CELL_MATCH:
            begin
                hit_next  = key_hit;
                qsel_next = pos_hit;
            end
            CELL_PUSH:
            begin
                // first free position takes the new id
                if (lower_valid && !valid_reg)
                begin
                    valid_next = 1'b1;
                    id_next    = key[ID_BITS-1:0];
                end
            end
            CELL_REMOVE:
            begin
                // close the gap from above
                if (shift_en)
                begin
                    valid_next = upper_valid;
                    id_next    = upper_id;
                end
            end
            CELL_LIFT:
            begin
                // slide down, the top position takes the lifted id
                if (shift_en && valid_reg)
                begin
                    id_next = upper_valid ? upper_id : key[ID_BITS-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            qsel_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
            qsel_reg  <= qsel_next;
        end
    end

    // stored id, only meaningful while valid
    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign stat.valid = valid_reg;
    assign stat.hit   = hit_reg;
    assign stat.qsel  = qsel_reg;
    assign id         = id_reg;
    assign sel_term   = qsel_reg ? id_reg : '0;
    assign top_term   = (valid_reg && !upper_valid) ? id_reg : '0;

endmodule

@@ rtl/layer_order_table.sv @@
// layer order table: a chain of order cells driven by a request sequencer
//
// Requests arrive on req (valid/ready) and each produces exactly one response
// on rsp. The table is a row of MAX_ENTRIES cells, cell 0 the bottom of the
// order; each cell keeps one id and exchanges it with its upper neighbor when
// the order shifts.
// Sequence: accept, a compare state (S_MATCH), an execute state (S_EXEC),
// then the output state loads the response into the output register. Destroy
// of the active entry passes through S_TOP to pick the new top, unless it was
// the last entry. Open repeats the compare/execute pair once for every
// candidate id that is already taken.
// Flow: one request at a time; req.ready is high only while the sequencer is
// idle, so a new request is taken as soon as the previous one has reached the
// output register, even if that response is still waiting.
// Reset: empty table, next id 1, no active entry; no clearing pass is needed.
// When rsp is stalled the response holds and the sequencer waits in its
// output state with the next result until the output register frees up.
module layer_order_table
    import lot_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int ID_BITS     = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    lot_req_if.sink   req,
    lot_rsp_if.source rsp
);

    localparam int KEY_W = (ID_BITS > WIN_ID_W) ? ID_BITS : WIN_ID_W;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    seq_state_t           state_reg, state_next;
    action_t              act_reg;
    logic [WIN_ID_W-1:0]  win_reg;
    logic [POS_W-1:0]     qpos_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ID_BITS-1:0]   next_id_reg, next_id_next;
    logic [ID_BITS-1:0]   active_reg, active_next;
    logic                 res_ok_reg, res_ok_next;
    logic [ID_BITS-1:0]   res_id_reg, res_id_next;

    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic [WIN_ID_W-1:0]  out_id_reg;
    logic [COUNT_W-1:0]   out_cnt_reg;
    logic [WIN_ID_W-1:0]  out_act_reg;

    cell_ctl_t            ctl;
    logic [KEY_W-1:0]     key;
    cell_stat_t           stat_arr [MAX_ENTRIES];
    logic [ID_BITS-1:0]   id_arr   [MAX_ENTRIES];
    logic [ID_BITS-1:0]   sel_arr  [MAX_ENTRIES];
    logic [ID_BITS-1:0]   top_arr  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_vec;
    logic [MAX_ENTRIES-1:0] hit_vec;
    logic [MAX_ENTRIES-1:0] qsel_vec;
    logic [MAX_ENTRIES-1:0] shift_vec;
    logic [ID_BITS-1:0]   sel_or;
    logic [ID_BITS-1:0]   top_or;
    logic                 any_hit;
    logic [ID_BITS-1:0]   id_inc;
    logic [ID_BITS-1:0]   id_adv;
    logic                 load_out;

    // key seen by the cells: candidate id for open, named id otherwise
    assign key = (act_reg == ACT_OPEN) ? KEY_W'(next_id_reg) : KEY_W'(win_reg);

    // gather cell status
    always_comb
    begin
        sel_or = '0;
        top_or = '0;
        for (int p = 0; p < MAX_ENTRIES; p++)
        begin
            valid_vec[p] = stat_arr[p].valid;
            hit_vec[p]   = stat_arr[p].hit;
            qsel_vec[p]  = stat_arr[p].qsel;
            sel_or       = sel_or | sel_arr[p];
            top_or       = top_or | top_arr[p];
        end
    end

    // ids are unique, so the hit is one-hot; cells at and above it shift
    assign any_hit   = |hit_vec;
    assign shift_vec = ~(hit_vec - MAX_ENTRIES'(1));

    // cell row
    for (genvar p = 0; p < MAX_ENTRIES; p++)
    begin : g_cell
        logic               lower_valid;
        logic               upper_valid;
        logic [ID_BITS-1:0] upper_id;

        if (p == 0)
        begin : g_bottom
            assign lower_valid = 1'b1;
        end
        else
        begin : g_lower
            assign lower_valid = valid_vec[p-1];
        end

        if (p == MAX_ENTRIES - 1)
        begin : g_top
            assign upper_valid = 1'b0;
            assign upper_id    = '0;
        end
        else
        begin : g_upper
            assign upper_valid = valid_vec[p+1];
            assign upper_id    = id_arr[p+1];
        end

        lot_cell #(
            .INDEX   (p),
            .ID_BITS (ID_BITS),
            .KEY_W   (KEY_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .key         (key),
            .shift_en    (shift_vec[p]),
            .lower_valid (lower_valid),
            .upper_valid (upper_valid),
            .upper_id    (upper_id),
            .stat        (stat_arr[p]),
            .id          (id_arr[p]),
            .sel_term    (sel_arr[p]),
            .top_term    (top_arr[p])
        );
    end

    // next id after the candidate, skipping zero
    assign id_inc = next_id_reg + ID_BITS'(1);
    assign id_adv = (id_inc == '0) ? ID_BITS'(1) : id_inc;

    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);

    // request sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        next_id_next = next_id_reg;
        active_next  = active_reg;
        res_ok_next  = res_ok_reg;
        res_id_next  = res_id_reg;
        ctl.op       = CELL_HOLD;
        ctl.qpos     = qpos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                ctl.op     = CELL_MATCH;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_ok_next = 1'b0;
                res_id_next = '0;
                state_next  = S_OUT;
                case (act_reg)
                    ACT_OPEN:
                    begin
                        // a free entry always leaves a free id among the next
                        // few candidates, so the search always ends
                        if (count_reg != CNT_W'(MAX_ENTRIES))
                        begin
                            next_id_next = id_adv;
                            if (any_hit)
                            begin
                                state_next = S_MATCH;
                            end
                            else
                            begin
                                ctl.op      = CELL_PUSH;
                                count_next  = count_reg + CNT_W'(1);
                                active_next = next_id_reg;
                                res_ok_next = 1'b1;
                                res_id_next = next_id_reg;
                            end
                        end
                    end
                    ACT_DESTROY:
                    begin
                        if (any_hit)
                        begin
                            ctl.op      = CELL_REMOVE;
                            count_next  = count_reg - CNT_W'(1);
                            res_ok_next = 1'b1;
                            if (KEY_W'(active_reg) == key)
                            begin
                                if (count_reg == CNT_W'(1))
                                begin
                                    active_next = '0;
                                end
                                else
                                begin
                                    state_next = S_TOP;
                                end
                            end
                        end
                    end
                    ACT_RAISE:
                    begin
                        if (any_hit)
                        begin
                            ctl.op      = CELL_LIFT;
                            res_ok_next = 1'b1;
                        end
                    end
                    ACT_ACTIVATE:
                    begin
                        if (any_hit)
                        begin
                            ctl.op      = CELL_LIFT;
                            active_next = key[ID_BITS-1:0];
                            res_ok_next = 1'b1;
                        end
                    end
                    ACT_QUERY:
                    begin
                        res_ok_next = |qsel_vec;
                        res_id_next = sel_or;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_TOP:
            begin
                // the destroyed entry was active: the new top takes over
                active_next = top_or;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer and table control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            next_id_reg <= ID_BITS'(1);
            active_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            active_reg  <= active_next;
        end
    end

    // request capture and pending result
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            act_reg  <= req.action;
            win_reg  <= req.window_id;
            qpos_reg <= req.stack_position;
        end
        res_ok_reg <= res_ok_next;
        res_id_reg <= res_id_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_ok_reg  <= res_ok_reg;
            out_id_reg  <= WIN_ID_W'(res_id_reg);
            out_cnt_reg <= COUNT_W'(count_reg);
            out_act_reg <= WIN_ID_W'(active_reg);
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.result_id   = out_id_reg;
    assign rsp.entry_count = out_cnt_reg;
    assign rsp.active_id   = out_act_reg;

endmodule

@@ rtl/lot_chk.sv @@
// port-level checks of the layer order table and their binding
module lot_chk
    import lot_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                ok,
    input logic [WIN_ID_W-1:0] result_id,
    input logic [COUNT_W-1:0]  entry_count,
    input logic [WIN_ID_W-1:0] active_id
);

    // a stalled response stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped while stalled");

    // one request at a time: ready falls right after an item is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in progress");

    // a failed request never reports an id
    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> result_id == '0)
        else $error("failed request reports an id");

    // an empty table has no active entry
    a_empty_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_count == '0 |-> active_id == '0)
        else $error("active id reported with an empty table");

endmodule

bind layer_order_table lot_chk u_lot_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .ok          (rsp.ok),
    .result_id   (rsp.result_id),
    .entry_count (rsp.entry_count),
    .active_id   (rsp.active_id)
);

@@ dv/lot_tb_pkg.sv @@
`timescale 1ns / 1ps
// prediction and response checking for the layer order table testbench
package lot_tb_pkg;
    import lot_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int REPORT_LIMIT = 10;

    // action codes the block does not define
    localparam action_t ACT_UNUSED_FIRST = 3'd5;
    localparam action_t ACT_UNUSED_LAST  = 3'd7;

    typedef logic [WIN_ID_W-1:0] win_id_t;
    typedef logic [POS_W-1:0]    slot_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef struct packed {
        logic    ok;
        win_id_t result_id;
        count_t  entry_count;
        win_id_t active_id;
    } table_rsp_t;

    class table_scoreboard;
        bit         slot_used[TABLE_DEPTH];
        win_id_t    slot_ident[TABLE_DEPTH];
        slot_t      order_list[TABLE_DEPTH];
        count_t     used_count;
        win_id_t    next_ident;
        win_id_t    current_active;
        win_id_t    last_opened;
        win_id_t    last_gone;
        table_rsp_t awaited[$];
        int         errors;

        function new();
            foreach (slot_used[i])
            begin
                slot_used[i]  = 1'b0;
                slot_ident[i] = '0;
                order_list[i] = '0;
            end
            used_count     = '0;
            next_ident     = 1;
            current_active = '0;
            last_opened    = '0;
            last_gone      = '0;
            errors         = 0;
        endfunction

        // slot holding an id, TABLE_DEPTH when there is none
        function int slot_holding(win_id_t id);
            if (id == '0)
                return TABLE_DEPTH;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (slot_used[i] && slot_ident[i] == id)
                    return i;
            return TABLE_DEPTH;
        endfunction

        function int order_pos(int slot);
            for (int p = 0; p < used_count; p++)
                if (order_list[p] == slot)
                    return p;
            return used_count;
        endfunction

        function void close_gap(int pos);
            for (int p = pos + 1; p < used_count; p++)
                order_list[p - 1] = order_list[p];
        endfunction

        // move an entry to the top of the order
        function bit lift(win_id_t id);
            int slot;
            int pos;
            slot = slot_holding(id);
            if (slot == TABLE_DEPTH)
                return 1'b0;
            pos = order_pos(slot);
            if (pos >= used_count)
                return 1'b0;
            close_gap(pos);
            order_list[used_count - 1] = slot_t'(slot);
            return 1'b1;
        endfunction

        // next free id, wrapping past zero; zero if the search runs out
        function win_id_t draw_ident();
            win_id_t cand;
            for (int tries = 0; tries <= TABLE_DEPTH; tries++)
            begin
                cand       = next_ident;
                next_ident = next_ident + 1'b1;
                if (next_ident == '0)
                    next_ident = 1;
                if (cand != '0 && slot_holding(cand) == TABLE_DEPTH)
                    return cand;
            end
            return '0;
        endfunction

        // apply an accepted item to the table and queue its response
        function void note_request(action_t act, win_id_t id, slot_t pos);
            table_rsp_t expd;
            int         slot;
            int         free_slot;
            int         at;
            bit         had_focus;
            win_id_t    nid;
            expd = '0;
            case (act)
                ACT_OPEN:
                begin
                    free_slot = TABLE_DEPTH;
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                        if (!slot_used[i])
                            free_slot = i;
                    if (free_slot < TABLE_DEPTH && used_count < TABLE_DEPTH)
                    begin
                        nid = draw_ident();
                        if (nid != '0)
                        begin
                            slot_used[free_slot]   = 1'b1;
                            slot_ident[free_slot]  = nid;
                            order_list[used_count] = slot_t'(free_slot);
                            used_count++;
                            current_active = nid;
                            last_opened    = nid;
                            expd.ok        = 1'b1;
                            expd.result_id = nid;
                        end
                    end
                end
                ACT_DESTROY:
                begin
                    slot = slot_holding(id);
                    if (slot < TABLE_DEPTH)
                    begin
                        at = order_pos(slot);
                        if (at < used_count)
                        begin
                            had_focus        = (current_active == id);
                            slot_used[slot]  = 1'b0;
                            slot_ident[slot] = '0;
                            close_gap(at);
                            used_count--;
                            // removing the active entry hands focus to the new top
                            if (had_focus)
                                current_active = (used_count == 0) ? '0 :
                                    slot_ident[order_list[used_count - 1]];
                            last_gone = id;
                            expd.ok   = 1'b1;
                        end
                    end
                end
                ACT_RAISE:
                    expd.ok = lift(id);
                ACT_ACTIVATE:
                begin
                    if (lift(id))
                    begin
                        current_active = id;
                        expd.ok        = 1'b1;
                    end
                end
                ACT_QUERY:
                begin
                    if (pos < used_count)
                    begin
                        expd.result_id = slot_ident[order_list[pos]];
                        expd.ok        = 1'b1;
                    end
                end
                default:
                    ;
            endcase
            expd.entry_count = used_count;
            expd.active_id   = current_active;
            awaited.push_back(expd);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%s", msg);
        endfunction

        // compare an accepted response with the oldest expectation
        function void check_response(logic ok, win_id_t rid, count_t cnt, win_id_t act);
            table_rsp_t expd;
            if (awaited.size() == 0)
            begin
                flag($sformatf("unexpected response ok=%0d id=%0d count=%0d active=%0d",
                               ok, rid, cnt, act));
                return;
            end
            expd = awaited.pop_front();
            if (ok !== expd.ok || rid !== expd.result_id ||
                cnt !== expd.entry_count || act !== expd.active_id)
                flag($sformatf({"response mismatch: expected ok=%0d id=%0d count=%0d ",
                                "active=%0d, got ok=%0d id=%0d count=%0d active=%0d"},
                               expd.ok, expd.result_id, expd.entry_count, expd.active_id,
                               ok, rid, cnt, act));
        endfunction

        // some id currently in the table, zero when empty
        function win_id_t pick_live_id();
            if (used_count == 0)
                return '0;
            return slot_ident[order_list[$urandom_range(0, used_count - 1)]];
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

endpackage

@@ dv/tb_layer_order_table.sv @@
`timescale 1ns / 1ps
// top-level testbench of the layer order table
module tb_layer_order_table;
    import lot_pkg::*;
    import lot_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int SEGMENT_ITEMS = 110;
    localparam int SEGMENTS      = 12;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    bit   send_gaps;
    bit   recv_gaps;

    table_scoreboard board = new();

    lot_req_if req_ch();
    lot_rsp_if rsp_ch();

    layer_order_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly back-to-back, sometimes a few cycles, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one item and wait for it to be taken
    task automatic send_request(action_t act, win_id_t id, slot_t pos);
        int gap;
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.action         <= act;
        req_ch.window_id      <= id;
        req_ch.stack_position <= pos;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(act, id, pos);
    endtask

    // random item, biased toward filling or draining the table
    task automatic random_request(bit fill);
        action_t act;
        win_id_t id;
        slot_t   pos;
        int      r;
        int      w_open;
        int      w_destroy;
        w_open    = fill ? 45 : 12;
        w_destroy = fill ? 10 : 40;
        r = $urandom_range(0, 99);
        if (r < w_open)
            act = ACT_OPEN;
        else if (r < w_open + w_destroy)
            act = ACT_DESTROY;
        else if (r < w_open + w_destroy + 14)
            act = ACT_RAISE;
        else if (r < w_open + w_destroy + 28)
            act = ACT_ACTIVATE;
        else if (r < 96)
            act = ACT_QUERY;
        else
            act = action_t'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));

        // mostly live ids, some none, stale or arbitrary
        r = $urandom_range(0, 9);
        if (r == 0)
            id = '0;
        else if (r == 1 || act == ACT_OPEN)
            id = win_id_t'($urandom);
        else if (r == 2)
            id = board.last_gone;
        else
            id = board.pick_live_id();

        if ($urandom_range(0, 4) != 0 && board.used_count != 0)
            pos = slot_t'($urandom_range(0, board.used_count - 1));
        else
            pos = slot_t'($urandom);
        send_request(act, id, pos);
    endtask

    // response side back-pressure
    initial
    begin
        forever
        begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (recv_gaps)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            board.check_response(rsp_ch.ok, rsp_ch.result_id, rsp_ch.entry_count,
                                 rsp_ch.active_id);
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int      mode;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.action         <= ACT_OPEN;
        req_ch.window_id      <= '0;
        req_ch.stack_position <= '0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table corner cases
        send_request(ACT_QUERY, '0, '1);
        send_request(ACT_DESTROY, '0, '0);
        send_request(ACT_UNUSED_LAST, '1, '1);

        // fill to capacity, then one open too many
        repeat (TABLE_DEPTH) send_request(ACT_OPEN, '0, '0);
        send_request(ACT_OPEN, '1, '0);
        send_request(ACT_QUERY, '0, '1);
        send_request(ACT_QUERY, '0, '0);

        // reorder and remove, including the active entry
        send_request(ACT_RAISE, 16'd1, '0);
        send_request(ACT_ACTIVATE, 16'd3, '0);
        send_request(ACT_DESTROY, 16'd3, '0);
        send_request(ACT_DESTROY, 16'd16, '0);
        send_request(ACT_RAISE, '1, '0);

        // open and close a few entries back to back with low ids still held
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        repeat (8)
        begin
            send_request(ACT_OPEN, '0, '0);
            send_request(ACT_DESTROY, board.last_opened, '0);
        end

        // random segments alternating fill and drain
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            mode      = $urandom_range(0, 3);
            send_gaps = (mode & 1) != 0;
            recv_gaps = (mode & 2) != 0;
            repeat (SEGMENT_ITEMS) random_request(seg % 2 == 0);
        end
        req_ch.valid <= 1'b0;

        // drain outstanding responses
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/lot_pkg.sv
rtl/lot_if.sv
rtl/lot_cell.sv
rtl/layer_order_table.sv
rtl/lot_chk.sv
dv/lot_tb_pkg.sv
dv/tb_layer_order_table.sv
